FILE: hdl/psot_pkg.sv
// Shared types and constants for the price sorted order table.
package psot_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_MODIFY = 2'd1,
    OP_REMOVE = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0] id;
    logic [30:0] price;
    logic [30:0] quantity;
    logic        side;
  } entry_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] order_id;
    logic [30:0] price;
    logic [30:0] quantity;
    logic        side;
    logic [3:0]  position;
  } cmd_t;

  // Per-operation enables broadcast to every cell.
  typedef struct packed {
    logic add_en;
    logic mod_en;
    logic rem_en;
  } cell_ctl_t;

endpackage

FILE: hdl/psot_req_if.sv
// Request channel: one table operation per beat.
interface psot_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] order_id;
  logic [30:0] price;
  logic [30:0] quantity;
  logic        side;
  logic [3:0]  position;

  modport source (
    output valid, op, order_id, price, quantity, side, position,
    input  ready
  );
  modport sink (
    input  valid, op, order_id, price, quantity, side, position,
    output ready
  );
endinterface

FILE: hdl/psot_rsp_if.sv
// Response channel: one result per beat.
interface psot_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] out_id;
  logic [30:0] out_price;
  logic [30:0] out_quantity;
  logic        out_side;
  logic [4:0]  count;

  modport source (
    output valid, status, out_id, out_price, out_quantity, out_side, count,
    input  ready
  );
  modport sink (
    input  valid, status, out_id, out_price, out_quantity, out_side, count,
    output ready
  );
endinterface

FILE: hdl/psot_cell.sv
// One slot of the sorted table: holds an entry and shifts with its neighbours.
module psot_cell
  import psot_pkg::*;
(
  input  logic      clk,
  input  cmd_t      cmd,
  input  cell_ctl_t ctl,
  input  logic      occupied,
  input  logic      at_or_above_left,
  input  logic      hit_before,
  input  entry_t    left,
  input  entry_t    right,
  output entry_t    entry,
  output logic      at_or_above,
  output logic      id_hit
);

  entry_t fresh;

  // An empty slot counts as above any price, so the insert point is found
  assign at_or_above = !occupied || (entry.price >= cmd.price);
  assign id_hit      = occupied && (entry.id == cmd.order_id);

  assign fresh = '{id: cmd.order_id, price: cmd.price,
                   quantity: cmd.quantity, side: cmd.side};

  always_ff @(posedge clk) begin
    if (ctl.add_en) begin
      // shift up behind the insert point, take the new order at it
      if (at_or_above_left) begin
        entry <= left;
      end else if (at_or_above) begin
        entry <= fresh;
      end
    end
    if (ctl.mod_en && id_hit && !hit_before) begin
      entry.quantity <= cmd.quantity;
    end
    if (ctl.rem_en && (id_hit || hit_before)) begin
      entry <= right;
    end
  end

endmodule

FILE: hdl/price_sorted_order_table.sv
// Price sorted order table: top level with command register, cell chain and result register.
//
// Holds up to DEPTH orders in a row of cells kept in ascending price order;
// equal prices sit newest first, and modify and remove act on the first
// entry in that order whose id matches. An accepted beat is captured in a
// command register. In the cycle after acceptance every cell compares against
// it at once. At the first edge with the result register free, the cells
// shift, insert or update, and the result is loaded into the output
// register, so a request beat passes through the command register and then
// the output register. A new request can be taken every cycle as long as
// results are drained, since the next command executes against the updated
// cells. While a result waits, the command register holds its beat, and
// ready drops once both registers are occupied. The execute cycle is set
// by the cell compares plus a log-depth prefix OR over the id-hit flags that
// picks the first match. The table is empty after reset with no clearing
// pass; slots beyond the count are never read. Every operation other than a
// read reports zero entry fields, and so does a read of a position at or
// beyond the count. An add into a full table is refused.
module price_sorted_order_table
  import psot_pkg::*;
(
  input logic      clk,
  input logic      rst,
  psot_req_if.sink   req,
  psot_rsp_if.source rsp
);

  cmd_t             cmd;
  logic             cmd_valid;
  logic             exec;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             full;
  logic             found;
  logic             pos_ok;
  logic [31:0]      pos_ext;
  logic [IDX_W-1:0] rd_idx;
  cell_ctl_t        ctl;

  entry_t           cell_q [DEPTH];
  logic [DEPTH-1:0] occ;
  logic [DEPTH-1:0] above;
  logic [DEPTH-1:0] hit;
  logic [DEPTH-1:0] hit_pre;
  logic [DEPTH-1:0] hit_before;

  status_t          res_status;
  entry_t           res_entry;
  logic [31:0]      cnt_ext;

  logic             rsp_valid;
  status_t          rsp_status;
  entry_t           rsp_entry;
  logic [4:0]       rsp_count;

  // Execute when the command is held and the result register is free
  assign exec      = cmd_valid && (!rsp_valid || rsp.ready);
  assign req.ready = !cmd_valid || exec;

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cmd <= '{op: op_t'(req.op), order_id: req.order_id, price: req.price,
               quantity: req.quantity, side: req.side, position: req.position};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      rsp_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (req.valid && req.ready) begin
        cmd_valid <= 1'b1;
      end else if (exec) begin
        cmd_valid <= 1'b0;
      end
      if (exec) begin
        rsp_valid <= 1'b1;
        cnt       <= cnt_next;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Cell chain: slot 0 holds the lowest price
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   above_l;

    assign occ[i] = (CNT_W'(i) < cnt);

    if (i == 0) begin : g_first
      assign left_e  = cell_q[0];
      assign above_l = 1'b0;
    end else begin : g_mid
      assign left_e  = cell_q[i-1];
      assign above_l = above[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_e = cell_q[i];
    end else begin : g_inner
      assign right_e = cell_q[i+1];
    end

    psot_cell u_cell (
      .clk              (clk),
      .cmd              (cmd),
      .ctl              (ctl),
      .occupied         (occ[i]),
      .at_or_above_left (above_l),
      .hit_before       (hit_before[i]),
      .left             (left_e),
      .right            (right_e),
      .entry            (cell_q[i]),
      .at_or_above      (above[i]),
      .id_hit           (hit[i])
    );
  end

  // Prefix OR of the hit flags in log steps; shift once to exclude the cell itself
  always_comb begin
    hit_pre = hit;
    for (int s = 1; s < DEPTH; s = s * 2) begin
      hit_pre = hit_pre | (hit_pre << s);
    end
    hit_before = hit_pre << 1;
  end

  assign found   = |hit;
  assign full    = (cnt == CNT_W'(DEPTH));
  assign pos_ext = 32'(cmd.position);
  assign rd_idx  = pos_ext[IDX_W-1:0];
  assign pos_ok  = (pos_ext < 32'(cnt)) && (pos_ext < 32'(DEPTH));

  always_comb begin
    res_status = ST_OK;
    res_entry  = '0;
    cnt_next   = cnt;
    ctl        = '0;
    case (cmd.op)
      OP_ADD: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          ctl.add_en = exec;
          cnt_next   = CNT_W'(cnt + 1'b1);
        end
      end
      OP_MODIFY: begin
        if (!found) begin
          res_status = ST_NOT_FOUND;
        end else begin
          ctl.mod_en = exec;
        end
      end
      OP_REMOVE: begin
        if (!found) begin
          res_status = ST_NOT_FOUND;
        end else begin
          ctl.rem_en = exec;
          cnt_next   = CNT_W'(cnt - 1'b1);
        end
      end
      OP_READ: begin
        if (pos_ok) begin
          res_entry = cell_q[rd_idx];
        end else begin
          res_status = ST_EMPTY;
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  // Count is reported modulo the width of its field
  assign cnt_ext = 32'(cnt_next);

  always_ff @(posedge clk) begin
    if (exec) begin
      rsp_status <= res_status;
      rsp_entry  <= res_entry;
      rsp_count  <= cnt_ext[4:0];
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_status;
  assign rsp.out_id       = rsp_entry.id;
  assign rsp.out_price    = rsp_entry.price;
  assign rsp.out_quantity = rsp_entry.quantity;
  assign rsp.out_side     = rsp_entry.side;
  assign rsp.count        = rsp_count;

  // The count never runs past the number of cells
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DEPTH))
    else $error("order count exceeds table depth");

  // A refused add is only reported while the table is full
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_status == ST_FULL)) |-> full)
    else $error("table full reported with free slots");

  // An accepted add grows the table by one
  a_add_grow: assert property (@(posedge clk) disable iff (rst)
    (exec && (cmd.op == OP_ADD) && !full) |=> (cnt == CNT_W'($past(cnt) + 1'b1)))
    else $error("add did not grow the table");

  // A successful remove shrinks the table by one
  a_rem_shrink: assert property (@(posedge clk) disable iff (rst)
    (exec && (cmd.op == OP_REMOVE) && found) |=> (cnt == CNT_W'($past(cnt) - 1'b1)))
    else $error("remove did not shrink the table");

endmodule
